### design/eoie_pkg.sv
// shared types, constants and field layout of the eight-op instruction executor
`default_nettype none
package eoie_pkg;

  localparam int unsigned MEM_WORDS = 65536;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);
  localparam int unsigned REG_COUNT = 8;
  localparam int unsigned REG_AW    = $clog2(REG_COUNT);
  localparam int unsigned XLEN      = 32;
  localparam int unsigned PC_W      = 16;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 144;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_NOR  = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_JALR = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LDONE,
    ST_FETCH,
    ST_EXEC,
    ST_MEM
  } state_e;

  typedef struct packed {
    op_e               op;
    logic              rwe;
    logic [REG_AW-1:0] rwi;
    logic [XLEN-1:0]   rwv;
    logic              mwe;
    logic [MEM_AW-1:0] maddr;
    logic [XLEN-1:0]   mwv;
    logic [PC_W-1:0]   pc_next;
    logic              halt;
    logic              is_lw;
    logic              is_sw;
  } alu_res_t;

endpackage
`default_nettype wire

### design/eight_op_isa_instruction_executor.sv
// top level of the eight-op instruction executor: control sequencer and result register
//
// input stream: s_axis_tuser selects the transaction kind (load word or execute step),
// s_axis_tdata carries the load address and word. every input transaction gives exactly one
// result transaction on the m_axis stream, in order.
// a load writes the word memory in its accept cycle and reports from the LDONE state.
// a step fetches from the word memory in its accept cycle, reads both source registers from the
// register file in the FETCH state and executes in the EXEC state; lw adds the MEM state for
// the data read through the same single memory read port.
// a step after halt reports from the LDONE state, like a load, and changes nothing.
// the next transaction is accepted in the cycle the current one reports, so a new one is never
// taken before the current one is through; after sw it is not accepted in that cycle, since
// the store holds the memory write port in its report cycle.
// the result register decouples the output: a stalled receiver only stops the block once a
// new result is ready and the register is still full.
// reset clears pc, halt flag, instruction count and register file valid bits (registers read
// as zero); the word memory is not cleared and must be loaded before it is fetched or read.
`default_nettype none
module eight_op_isa_instruction_executor (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // load_addr[15:0], load_data[47:16]
  input  wire logic [47:0]  s_axis_tdata,
  // func[0]
  input  wire logic [0:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // pc_now[15:0], halted[16], executed_opcode[19:17], reg_write_en[20],
  // reg_write_index[23:21], reg_write_value[55:24], mem_write_en[56],
  // mem_write_addr[72:57], mem_write_value[104:73], instr_count[136:105], zero[143:137]
  output logic [143:0]      m_axis_tdata
);

  eoie_pkg::state_e                  st_q, st_d, st_acc;
  logic [eoie_pkg::PC_W-1:0]         pc_q, pc_d;
  logic                              halt_q, halt_d;
  logic [eoie_pkg::XLEN-1:0]         cnt_q, cnt_d;
  logic [eoie_pkg::XLEN-1:0]         instr_q;
  logic                              ld_q;
  logic [eoie_pkg::MEM_AW-1:0]       ld_addr_q;
  logic [eoie_pkg::XLEN-1:0]         ld_data_q;
  logic                              out_vld_q;
  logic [eoie_pkg::OUT_DATA_W-1:0]   out_data_q;
  logic [eoie_pkg::OUT_DATA_W-1:0]   out_data_d;

  logic                              in_fire, room, fin_state, fin_fire, step_fin;
  logic                              in_is_load;
  logic [eoie_pkg::MEM_AW-1:0]       in_addr;
  logic [eoie_pkg::XLEN-1:0]         in_word;

  logic                              ram_we, ram_re;
  logic [eoie_pkg::MEM_AW-1:0]       ram_waddr, ram_raddr;
  logic [eoie_pkg::XLEN-1:0]         ram_wdata, ram_rdata;

  logic                              rf_re, rf_we;
  logic [eoie_pkg::XLEN-1:0]         ra_val, rb_val, rf_wdata;
  eoie_pkg::alu_res_t                alu;

  logic [2:0]                        r_op;
  logic                              r_rwe, r_mwe;
  logic [eoie_pkg::REG_AW-1:0]       r_rwi;
  logic [eoie_pkg::XLEN-1:0]         r_rwv, r_mwv;
  logic [eoie_pkg::PC_W-1:0]         r_mwa;

  assign in_is_load = (s_axis_tuser[0] == eoie_pkg::FUNC_LOAD);
  assign in_addr    = s_axis_tdata[eoie_pkg::MEM_AW-1:0];
  assign in_word    = s_axis_tdata[47:16];

  assign room      = !out_vld_q || m_axis_tready;
  assign fin_state = (st_q == eoie_pkg::ST_LDONE) || (st_q == eoie_pkg::ST_MEM)
                  || ((st_q == eoie_pkg::ST_EXEC) && !alu.is_lw);
  assign fin_fire  = fin_state && room;
  assign step_fin  = fin_fire && (st_q != eoie_pkg::ST_LDONE);

  // a finishing store holds the memory write port
  assign s_axis_tready = (st_q == eoie_pkg::ST_IDLE)
                      || (fin_fire && !((st_q == eoie_pkg::ST_EXEC) && alu.is_sw));
  assign in_fire = s_axis_tvalid && s_axis_tready;

  assign pc_d   = step_fin ? alu.pc_next : pc_q;
  assign halt_d = halt_q | (step_fin & alu.halt);
  assign cnt_d  = step_fin ? (cnt_q + 32'd1) : cnt_q;

  eoie_ram #(
    .WIDTH (eoie_pkg::XLEN),
    .DEPTH (eoie_pkg::MEM_WORDS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  eoie_regfile u_rf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .re_i      (rf_re),
    .ra_addr_i (ram_rdata[21:19]),
    .rb_addr_i (ram_rdata[18:16]),
    .ra_data_o (ra_val),
    .rb_data_o (rb_val),
    .we_i      (rf_we),
    .waddr_i   (alu.rwi),
    .wdata_i   (rf_wdata)
  );

  eoie_alu u_alu (
    .instr_i  (instr_q),
    .ra_val_i (ra_val),
    .rb_val_i (rb_val),
    .pc_i     (pc_q),
    .res_o    (alu)
  );

  assign rf_re    = (st_q == eoie_pkg::ST_FETCH);
  assign rf_we    = step_fin && alu.rwe;
  assign rf_wdata = (st_q == eoie_pkg::ST_MEM) ? ram_rdata : alu.rwv;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = in_addr;
    ram_wdata = in_word;
    ram_re    = 1'b0;
    ram_raddr = pc_d[eoie_pkg::MEM_AW-1:0];
    if (in_fire && in_is_load) begin
      ram_we = 1'b1;
    end else if (step_fin && alu.is_sw) begin
      ram_we    = 1'b1;
      ram_waddr = alu.maddr;
      ram_wdata = alu.mwv;
    end
    if ((st_q == eoie_pkg::ST_EXEC) && alu.is_lw) begin
      ram_re    = 1'b1;
      ram_raddr = alu.maddr;
    end else if (in_fire && !in_is_load && !halt_d) begin
      ram_re = 1'b1;
    end
  end

  always_comb begin
    st_acc = (in_is_load || halt_d) ? eoie_pkg::ST_LDONE : eoie_pkg::ST_FETCH;
    st_d   = st_q;
    case (st_q)
      eoie_pkg::ST_IDLE: begin
        if (in_fire) begin
          st_d = st_acc;
        end
      end
      eoie_pkg::ST_FETCH: begin
        st_d = eoie_pkg::ST_EXEC;
      end
      eoie_pkg::ST_EXEC: begin
        if (alu.is_lw) begin
          st_d = eoie_pkg::ST_MEM;
        end else if (fin_fire) begin
          st_d = in_fire ? st_acc : eoie_pkg::ST_IDLE;
        end
      end
      eoie_pkg::ST_LDONE, eoie_pkg::ST_MEM: begin
        if (fin_fire) begin
          st_d = in_fire ? st_acc : eoie_pkg::ST_IDLE;
        end
      end
      default: begin
        st_d = eoie_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    r_op  = eoie_pkg::OP_NOOP;
    r_rwe = 1'b0;
    r_rwi = '0;
    r_rwv = '0;
    r_mwe = 1'b0;
    r_mwa = '0;
    r_mwv = '0;
    if (st_q == eoie_pkg::ST_LDONE) begin
      if (ld_q) begin
        r_mwe = 1'b1;
        r_mwa = eoie_pkg::PC_W'(ld_addr_q);
        r_mwv = ld_data_q;
      end
    end else begin
      r_op  = alu.op;
      r_rwe = alu.rwe;
      r_rwi = alu.rwi;
      r_rwv = (st_q == eoie_pkg::ST_MEM) ? ram_rdata : alu.rwv;
      r_mwe = alu.mwe;
      if (alu.is_sw) begin
        r_mwa = eoie_pkg::PC_W'(alu.maddr);
        r_mwv = alu.mwv;
      end
    end
    out_data_d = {7'd0, cnt_d, r_mwv, r_mwa, r_mwe, r_rwv, r_rwi, r_rwe, r_op,
                  halt_d, pc_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= eoie_pkg::ST_IDLE;
      pc_q      <= '0;
      halt_q    <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      pc_q   <= pc_d;
      halt_q <= halt_d;
      cnt_q  <= cnt_d;
      if (fin_fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      out_data_q <= out_data_d;
    end
    if (in_fire) begin
      ld_q      <= in_is_load;
      ld_addr_q <= in_addr;
      ld_data_q <= in_word;
    end
    if (st_q == eoie_pkg::ST_FETCH) begin
      instr_q <= ram_rdata;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

### design/eoie_ram.sv
// generic single-write, single-read synchronous ram with registered read data
`default_nettype none
module eoie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### design/eoie_regfile.sv
// eight-entry register file: two read ports over mirrored rams, valid bits give zero after reset
`default_nettype none
module eoie_regfile (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          re_i,
  input  wire logic [eoie_pkg::REG_AW-1:0]   ra_addr_i,
  input  wire logic [eoie_pkg::REG_AW-1:0]   rb_addr_i,
  output logic      [eoie_pkg::XLEN-1:0]     ra_data_o,
  output logic      [eoie_pkg::XLEN-1:0]     rb_data_o,
  input  wire logic                          we_i,
  input  wire logic [eoie_pkg::REG_AW-1:0]   waddr_i,
  input  wire logic [eoie_pkg::XLEN-1:0]     wdata_i
);

  logic [eoie_pkg::REG_COUNT-1:0] vld_q;
  logic                           ra_vld_q;
  logic                           rb_vld_q;
  logic [eoie_pkg::XLEN-1:0]      ra_raw;
  logic [eoie_pkg::XLEN-1:0]      rb_raw;

  eoie_ram #(
    .WIDTH (eoie_pkg::XLEN),
    .DEPTH (eoie_pkg::REG_COUNT)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .re_i    (re_i),
    .raddr_i (ra_addr_i),
    .rdata_o (ra_raw)
  );

  eoie_ram #(
    .WIDTH (eoie_pkg::XLEN),
    .DEPTH (eoie_pkg::REG_COUNT)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .re_i    (re_i),
    .raddr_i (rb_addr_i),
    .rdata_o (rb_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      ra_vld_q <= 1'b0;
      rb_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        ra_vld_q <= vld_q[ra_addr_i];
        rb_vld_q <= vld_q[rb_addr_i];
      end
    end
  end

  assign ra_data_o = ra_vld_q ? ra_raw : '0;
  assign rb_data_o = rb_vld_q ? rb_raw : '0;

endmodule
`default_nettype wire

### design/eoie_alu.sv
// instruction decode and execute: register results, memory address, next pc
`default_nettype none
module eoie_alu (
  input  wire logic [eoie_pkg::XLEN-1:0] instr_i,
  input  wire logic [eoie_pkg::XLEN-1:0] ra_val_i,
  input  wire logic [eoie_pkg::XLEN-1:0] rb_val_i,
  input  wire logic [eoie_pkg::PC_W-1:0] pc_i,
  output eoie_pkg::alu_res_t             res_o
);

  logic [eoie_pkg::REG_AW-1:0] ra_idx;
  logic [eoie_pkg::REG_AW-1:0] rb_idx;
  logic [eoie_pkg::REG_AW-1:0] rd_idx;
  logic [eoie_pkg::XLEN-1:0]   off;
  logic [eoie_pkg::XLEN-1:0]   ea;
  logic [eoie_pkg::PC_W-1:0]   pc_inc;
  eoie_pkg::op_e               op;

  assign ra_idx = instr_i[21:19];
  assign rb_idx = instr_i[18:16];
  assign rd_idx = instr_i[2:0];
  assign off    = {{16{instr_i[15]}}, instr_i[15:0]};
  assign ea     = ra_val_i + off;
  assign pc_inc = pc_i + 16'd1;
  assign op     = eoie_pkg::op_e'(instr_i[24:22]);

  always_comb begin
    res_o         = '0;
    res_o.op      = op;
    res_o.maddr   = ea[eoie_pkg::MEM_AW-1:0];
    res_o.pc_next = pc_inc;
    case (op)
      eoie_pkg::OP_ADD: begin
        res_o.rwe = 1'b1;
        res_o.rwi = rd_idx;
        res_o.rwv = ra_val_i + rb_val_i;
      end
      eoie_pkg::OP_NOR: begin
        res_o.rwe = 1'b1;
        res_o.rwi = rd_idx;
        res_o.rwv = ~(ra_val_i | rb_val_i);
      end
      eoie_pkg::OP_LW: begin
        res_o.rwe   = 1'b1;
        res_o.rwi   = rb_idx;
        res_o.is_lw = 1'b1;
      end
      eoie_pkg::OP_SW: begin
        res_o.mwe   = 1'b1;
        res_o.mwv   = rb_val_i;
        res_o.is_sw = 1'b1;
      end
      eoie_pkg::OP_BEQ: begin
        if (ra_val_i == rb_val_i) begin
          res_o.pc_next = pc_inc + off[eoie_pkg::PC_W-1:0];
        end
      end
      eoie_pkg::OP_JALR: begin
        res_o.rwe     = 1'b1;
        res_o.rwi     = rb_idx;
        res_o.rwv     = eoie_pkg::XLEN'(pc_inc);
        res_o.pc_next = (ra_idx == rb_idx) ? pc_inc : ra_val_i[eoie_pkg::PC_W-1:0];
      end
      eoie_pkg::OP_HALT: begin
        res_o.halt = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### tb/sv/eight_op_isa_instruction_executor_test.sv
// self-checking testbench for the eight-op instruction executor with random programs and stalls
module eight_op_isa_instruction_executor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PLAN_LEN     = 24;

  typedef struct packed {
    logic [31:0]     count;
    logic [31:0]     mwv;
    logic [15:0]     maddr;
    logic            mwe;
    logic [31:0]     rwv;
    logic [2:0]      rwi;
    logic            rwe;
    eoie_pkg::op_e   op;
    logic            halted;
    logic [15:0]     pc;
  } outcome_t;

  typedef struct {
    logic        func;
    logic [15:0] addr;
    logic [31:0] data;
    bit          typed;
    outcome_t    want;
  } vector_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata;
  logic [0:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;

  // processor state as the block should hold it
  logic [15:0] prog_pc;
  logic [31:0] gpr [eoie_pkg::REG_COUNT];
  bit   [31:0] word_mem [eoie_pkg::MEM_WORDS];
  bit          word_set [eoie_pkg::MEM_WORDS];
  logic        stopped;
  logic [31:0] retired;

  outcome_t pending_results [$];
  vector_t  plan [PLAN_LEN];
  outcome_t seen_out;
  outcome_t want_out;
  int       sent;
  int       delivered = 0;
  int       errors = 0;
  int       cycles = 0;

  eight_op_isa_instruction_executor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [31:0] encode(eoie_pkg::op_e op, logic [2:0] ra, logic [2:0] rb,
                                         logic [15:0] off);
    return {7'd0, op, ra, rb, off};
  endfunction

  function automatic logic [15:0] data_addr(logic [31:0] w);
    logic [31:0] sum;
    sum = gpr[w[21:19]] + {{16{w[15]}}, w[15:0]};
    return sum[15:0];
  endfunction

  function automatic outcome_t execute_item(logic func, logic [15:0] addr, logic [31:0] data);
    outcome_t    r;
    logic [31:0] w;
    logic [2:0]  ra;
    logic [2:0]  rb;
    logic [15:0] next;
    r = '0;
    r.op = eoie_pkg::OP_NOOP;
    if (func == eoie_pkg::FUNC_LOAD) begin
      word_mem[addr] = data;
      word_set[addr] = 1'b1;
      r.mwe = 1'b1;
      r.maddr = addr;
      r.mwv = data;
    end else if (!stopped) begin
      w = word_mem[prog_pc];
      ra = w[21:19];
      rb = w[18:16];
      r.op = eoie_pkg::op_e'(w[24:22]);
      next = prog_pc + 16'd1;
      case (r.op)
        eoie_pkg::OP_ADD: begin
          r.rwe = 1'b1;
          r.rwi = w[2:0];
          r.rwv = gpr[ra] + gpr[rb];
        end
        eoie_pkg::OP_NOR: begin
          r.rwe = 1'b1;
          r.rwi = w[2:0];
          r.rwv = ~(gpr[ra] | gpr[rb]);
        end
        eoie_pkg::OP_LW: begin
          r.rwe = 1'b1;
          r.rwi = rb;
          r.rwv = word_mem[data_addr(w)];
        end
        eoie_pkg::OP_SW: begin
          r.mwe = 1'b1;
          r.maddr = data_addr(w);
          r.mwv = gpr[rb];
          word_mem[r.maddr] = r.mwv;
          word_set[r.maddr] = 1'b1;
        end
        eoie_pkg::OP_BEQ: begin
          if (gpr[ra] == gpr[rb]) next = prog_pc + w[15:0] + 16'd1;
        end
        eoie_pkg::OP_JALR: begin
          // link register is written before the target is read
          r.rwe = 1'b1;
          r.rwi = rb;
          r.rwv = {16'd0, prog_pc + 16'd1};
          gpr[rb] = r.rwv;
          next = gpr[ra][15:0];
        end
        eoie_pkg::OP_HALT: stopped = 1'b1;
        default: ;
      endcase
      if (r.rwe && r.op != eoie_pkg::OP_JALR) gpr[r.rwi] = r.rwv;
      prog_pc = next;
      retired = retired + 32'd1;
    end
    r.pc = prog_pc;
    r.halted = stopped;
    r.count = retired;
    return r;
  endfunction

  function automatic logic [31:0] random_instr();
    eoie_pkg::op_e op;
    logic [15:0]   off;
    case ($urandom_range(0, 9))
      0, 1:    op = eoie_pkg::OP_ADD;
      2:       op = eoie_pkg::OP_NOR;
      3:       op = eoie_pkg::OP_LW;
      4:       op = eoie_pkg::OP_SW;
      5, 6:    op = eoie_pkg::OP_BEQ;
      7:       op = eoie_pkg::OP_JALR;
      default: op = eoie_pkg::OP_NOOP;
    endcase
    case ($urandom_range(0, 3))
      0:       off = 16'($urandom());
      1:       off = -16'($urandom_range(1, 8));
      default: off = 16'($urandom_range(0, 8));
    endcase
    return encode(op, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), off)
           | {7'($urandom()), 25'd0};
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic issue(logic func, logic [15:0] addr, logic [31:0] data, bit typed,
                       outcome_t want);
    int       gap;
    outcome_t predicted;
    gap = pick_gap((sent / 200) % 3 == 1);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata <= {data, addr};
    s_axis_tuser <= func;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = execute_item(func, addr, data);
    pending_results.push_back(typed ? want : predicted);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, actual %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin : stimulus
    int          issued;
    logic [31:0] w;
    logic        f;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    prog_pc = '0;
    stopped = 1'b0;
    retired = '0;
    foreach (gpr[i]) gpr[i] = '0;
    sent = 0;
    plan = '{
      '{eoie_pkg::FUNC_LOAD, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
        '{pc: 16'd0, op: eoie_pkg::OP_NOOP, mwe: 1'b1, maddr: 16'hFFFF, mwv: 32'hFFFF_FFFF,
          default: '0}},
      '{eoie_pkg::FUNC_LOAD, 16'h0000, encode(eoie_pkg::OP_NOR, 3'd0, 3'd0, 16'd1), 1'b0, '0},
      '{eoie_pkg::FUNC_LOAD, 16'h0001, encode(eoie_pkg::OP_ADD, 3'd1, 3'd1, 16'd2), 1'b0, '0},
      '{eoie_pkg::FUNC_LOAD, 16'h0002, encode(eoie_pkg::OP_SW, 3'd0, 3'd1, 16'h7FFF), 1'b0,
        '0},
      '{eoie_pkg::FUNC_LOAD, 16'h0003, encode(eoie_pkg::OP_LW, 3'd1, 3'd3, 16'h8000), 1'b0,
        '0},
      '{eoie_pkg::FUNC_LOAD, 16'h0004, encode(eoie_pkg::OP_BEQ, 3'd1, 3'd3, 16'd1), 1'b0, '0},
      '{eoie_pkg::FUNC_LOAD, 16'h0005, encode(eoie_pkg::OP_HALT, 3'd0, 3'd0, 16'd0), 1'b0,
        '0},
      '{eoie_pkg::FUNC_LOAD, 16'h0006, encode(eoie_pkg::OP_ADD, 3'd2, 3'd1, 16'd0), 1'b0, '0},
      '{eoie_pkg::FUNC_LOAD, 16'h0007, encode(eoie_pkg::OP_JALR, 3'd4, 3'd4, 16'd0), 1'b0,
        '0},
      '{eoie_pkg::FUNC_LOAD, 16'h0008, encode(eoie_pkg::OP_BEQ, 3'd1, 3'd2, 16'h7FFF), 1'b0,
        '0},
      '{eoie_pkg::FUNC_LOAD, 16'h0009,
        encode(eoie_pkg::OP_NOOP, 3'd7, 3'd7, 16'hFFFF) | 32'hFE00_0000, 1'b0, '0},
      '{eoie_pkg::FUNC_LOAD, 16'h000A, encode(eoie_pkg::OP_JALR, 3'd1, 3'd6, 16'd0), 1'b0,
        '0},
      '{eoie_pkg::FUNC_STEP, 16'h0000, 32'h0, 1'b1,
        '{pc: 16'd1, op: eoie_pkg::OP_NOR, rwe: 1'b1, rwi: 3'd1, rwv: 32'hFFFF_FFFF,
          count: 32'd1, default: '0}},
      '{eoie_pkg::FUNC_STEP, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
        '{pc: 16'd2, op: eoie_pkg::OP_ADD, rwe: 1'b1, rwi: 3'd2, rwv: 32'hFFFF_FFFE,
          count: 32'd2, default: '0}},
      '{eoie_pkg::FUNC_STEP, 16'h0000, 32'h0, 1'b0, '0},
      '{eoie_pkg::FUNC_STEP, 16'h0000, 32'h0, 1'b0, '0},
      '{eoie_pkg::FUNC_STEP, 16'h0000, 32'h0, 1'b0, '0},
      '{eoie_pkg::FUNC_STEP, 16'h0000, 32'h0, 1'b0, '0},
      '{eoie_pkg::FUNC_STEP, 16'h0000, 32'h0, 1'b0, '0},
      '{eoie_pkg::FUNC_STEP, 16'h0000, 32'h0, 1'b0, '0},
      '{eoie_pkg::FUNC_STEP, 16'h0000, 32'h0, 1'b0, '0},
      '{eoie_pkg::FUNC_STEP, 16'h0000, 32'h0, 1'b0, '0},
      '{eoie_pkg::FUNC_STEP, 16'h0000, 32'h0, 1'b0, '0},
      '{eoie_pkg::FUNC_STEP, 16'h0000, 32'h0, 1'b0, '0}
    };
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (plan[i]) issue(plan[i].func, plan[i].addr, plan[i].data, plan[i].typed,
                            plan[i].want);
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      w = word_mem[prog_pc];
      if ($urandom_range(0, 99) < 15) begin
        issue(eoie_pkg::FUNC_LOAD, 16'($urandom()), $urandom(), 1'b0, '0);
      end else if (!word_set[prog_pc] || w[24:22] == eoie_pkg::OP_HALT
                   || $urandom_range(0, 99) < 4) begin
        // only fetch words that were written, and keep halt for the end
        issue(eoie_pkg::FUNC_LOAD, prog_pc, random_instr(), 1'b0, '0);
      end else if (w[24:22] == eoie_pkg::OP_LW && !word_set[data_addr(w)]) begin
        issue(eoie_pkg::FUNC_LOAD, data_addr(w), $urandom(), 1'b0, '0);
      end else begin
        issue(eoie_pkg::FUNC_STEP, 16'($urandom()), $urandom(), 1'b0, '0);
      end
      issued++;
    end
    // halt, then steps that must do nothing and loads that still write
    issue(eoie_pkg::FUNC_LOAD, prog_pc,
          encode(eoie_pkg::OP_HALT, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                 16'($urandom())), 1'b0, '0);
    issue(eoie_pkg::FUNC_STEP, 16'($urandom()), $urandom(), 1'b0, '0);
    repeat (15) begin
      f = 1'($urandom_range(0, 1));
      issue(f, 16'($urandom()), $urandom(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS eight_op_isa_instruction_executor");
    end else begin
      $display("FAIL eight_op_isa_instruction_executor");
    end
    $finish;
  end

  initial begin : receiver
    int busy;
    bit held;
    m_axis_tready = 1'b0;
    held = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!held && delivered >= 300) begin
        // long hold-off so the block fills up and stalls its input
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      busy = pick_gap((delivered / 200) % 3 == 2);
      if (busy > 0) begin
        m_axis_tready <= 1'b0;
        repeat (busy) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_out = m_axis_tdata[136:0];
      if (pending_results.size() == 0) begin
        $error("result transaction with no pending input transaction");
        errors++;
      end else begin
        want_out = pending_results.pop_front();
        check_field("pc_now", 32'(want_out.pc), 32'(seen_out.pc));
        check_field("halted", 32'(want_out.halted), 32'(seen_out.halted));
        check_field("executed_opcode", 32'(want_out.op), 32'(seen_out.op));
        check_field("reg_write_en", 32'(want_out.rwe), 32'(seen_out.rwe));
        check_field("reg_write_index", 32'(want_out.rwi), 32'(seen_out.rwi));
        check_field("reg_write_value", want_out.rwv, seen_out.rwv);
        check_field("mem_write_en", 32'(want_out.mwe), 32'(seen_out.mwe));
        check_field("mem_write_addr", 32'(want_out.maddr), 32'(seen_out.maddr));
        check_field("mem_write_value", want_out.mwv, seen_out.mwv);
        check_field("instr_count", want_out.count, seen_out.count);
        check_field("zero", 32'd0, 32'(m_axis_tdata[143:137]));
      end
      delivered++;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL eight_op_isa_instruction_executor");
      $finish;
    end
  end

endmodule
